>>> rtl/core/uule_pkg.sv
// Shared types, constants and helper functions of the uuencode line encoder.
`timescale 1ns / 1ps

package uule_pkg;

    localparam int unsigned MAX_LINE_BYTES = 45;
    localparam int unsigned CNT_W          = 6;
    localparam int unsigned RAM_DEPTH      = 2 * MAX_LINE_BYTES;
    localparam int unsigned RAM_AW         = $clog2(RAM_DEPTH);
    localparam int unsigned Q_DEPTH        = 2;

    localparam logic [6:0] CHAR_BIAS = 7'd32;
    localparam logic [6:0] CHAR_NL   = 7'd10;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [6:0] char_out;
        logic       run_last;
    } t_out_item;

    // Work for the back end: an optional buffered line, then an optional trailer.
    typedef struct packed {
        logic             has_line;
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             eos;
    } t_line_cmd;

    function automatic logic [6:0] f_enc6(input logic [5:0] v);
        f_enc6 = {1'b0, v} + CHAR_BIAS;
    endfunction

    function automatic logic [RAM_AW-1:0] f_buf_addr(input logic bank,
                                                     input logic [CNT_W-1:0] idx);
        f_buf_addr = RAM_AW'(idx) + (bank ? RAM_AW'(MAX_LINE_BYTES) : RAM_AW'(0));
    endfunction

endpackage

>>> rtl/core/uule_line_ram.sv
// Two-bank line buffer: one write port and one read port with registered data.
`timescale 1ns / 1ps

module uule_line_ram (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [uule_pkg::RAM_AW-1:0] i_wr_addr,
    input  logic [7:0]                i_wr_data,
    input  logic                      i_rd_en,
    input  logic [uule_pkg::RAM_AW-1:0] i_rd_addr,
    output logic [7:0]                o_rd_data
);
    import uule_pkg::*;

    logic [7:0] r_mem [RAM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> rtl/core/uule_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module uule_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  uule_pkg::t_line_cmd i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output uule_pkg::t_line_cmd o_cmd,
    output logic                o_empty
);
    import uule_pkg::*;

    t_line_cmd r_slot [Q_DEPTH];
    logic      r_wptr;
    logic      r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(Q_DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |-> !i_push)
        else $error("command pushed into a full queue");
`endif

endmodule

>>> rtl/core/uule_front.sv
// Front end: takes requests, fills the line buffer and queues line commands.
`timescale 1ns / 1ps

module uule_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [uule_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  uule_pkg::t_in_item          i_in_data,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output uule_pkg::t_line_cmd         o_q_cmd,
    input  logic                        i_line_done,
    output logic                        o_wr_en,
    output logic [uule_pkg::RAM_AW-1:0] o_wr_addr,
    output logic [7:0]                  o_wr_data
);
    import uule_pkg::*;

    logic [CNT_W-1:0] r_line_bytes;
    logic [CNT_W-1:0] r_fill;
    logic             r_bank;
    logic [1:0]       r_pend;

    logic [CNT_W-1:0] w_eff;
    logic [CNT_W-1:0] w_fill_inc;
    logic             w_accept;
    logic             w_push_line;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        priority if (r_line_bytes == '0) begin
            w_eff = CNT_W'(1);
        end else if (r_line_bytes > CNT_W'(MAX_LINE_BYTES)) begin
            w_eff = CNT_W'(MAX_LINE_BYTES);
        end else begin
            w_eff = r_line_bytes;
        end
    end

    // The bank being filled is busy only when two lines are still pending in the back end.
    assign o_in_stall = i_q_full || ((i_in_data.kind == KIND_DATA) && (r_pend == 2'd2));
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_fill_inc = r_fill + CNT_W'(1);

    assign o_wr_en   = w_accept && (i_in_data.kind == KIND_DATA);
    assign o_wr_addr = f_buf_addr(r_bank, r_fill);
    assign o_wr_data = i_in_data.data_byte;

    always_comb begin
        o_q_push         = 1'b0;
        o_q_cmd.has_line = 1'b0;
        o_q_cmd.bank     = r_bank;
        o_q_cmd.count    = r_fill;
        o_q_cmd.eos      = 1'b0;
        if (w_accept) begin
            if (i_in_data.kind == KIND_DATA) begin
                o_q_push         = (w_fill_inc >= w_eff);
                o_q_cmd.has_line = 1'b1;
                o_q_cmd.count    = w_fill_inc;
            end else begin
                o_q_push         = 1'b1;
                o_q_cmd.has_line = (r_fill != '0);
                o_q_cmd.eos      = 1'b1;
            end
        end
    end

    assign w_push_line = o_q_push && o_q_cmd.has_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes <= CNT_W'(MAX_LINE_BYTES);
            r_fill       <= '0;
            r_bank       <= 1'b0;
            r_pend       <= 2'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_line_bytes <= i_cfg_data;
            end
            if (w_accept) begin
                if (o_q_push) begin
                    r_fill <= '0;
                end else begin
                    r_fill <= w_fill_inc;
                end
            end
            if (w_push_line) begin
                r_bank <= ~r_bank;
            end
            r_pend <= r_pend + 2'(w_push_line) - 2'(i_line_done);
        end
    end

`ifndef SYNTHESIS
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two lines pending in the back end");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CNT_W'(MAX_LINE_BYTES))
        else $error("line buffer fill passed its capacity");
`endif

endmodule

>>> rtl/core/uule_back.sv
// Back end: reads buffered lines and emits the encoded characters, one per cycle within a line while not stalled.
`timescale 1ns / 1ps

module uule_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  uule_pkg::t_line_cmd         i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_rd_en,
    output logic [uule_pkg::RAM_AW-1:0] o_rd_addr,
    input  logic [7:0]                  i_rd_data,
    output logic                        o_line_done,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output uule_pkg::t_out_item         o_out_data
);
    import uule_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_LEN, B_C0, B_C1, B_C2, B_C3, B_NL, B_SP, B_END
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_has_line;
    logic             r_bank;
    logic [CNT_W-1:0] r_cnt;
    logic             r_eos;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic [7:0]       r_prev;
    logic [7:0]       n_prev;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             w_adv;
    logic [7:0]       w_b1;
    logic [7:0]       w_b2;
    logic [CNT_W-1:0] w_idx1;
    logic [CNT_W-1:0] w_idx2;
    logic [CNT_W-1:0] w_idx3;

    assign w_adv  = !r_out_valid || !i_out_stall;
    assign w_idx1 = r_idx + CNT_W'(1);
    assign w_idx2 = r_idx + CNT_W'(2);
    assign w_idx3 = r_idx + CNT_W'(3);
    // Bytes past the end of the line read as zero padding.
    assign w_b1   = (w_idx1 < r_cnt) ? i_rd_data : 8'd0;
    assign w_b2   = (w_idx2 < r_cnt) ? i_rd_data : 8'd0;

    assign o_q_pop     = (r_state == B_IDLE) && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_line_done = w_adv && (r_state == B_NL);

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_prev         = r_prev;
        n_out.char_out = CHAR_NL;
        n_out.run_last = 1'b0;
        o_rd_en        = 1'b0;
        o_rd_addr      = f_buf_addr(r_bank, r_idx);
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_cmd.has_line ? B_LEN : B_SP;
                    n_idx   = '0;
                end
            end
            B_LEN: begin
                n_out.char_out = f_enc6(r_cnt);
                o_rd_en        = w_adv;
                n_state        = B_C0;
            end
            B_C0: begin
                n_out.char_out = f_enc6(i_rd_data[7:2]);
                n_prev         = i_rd_data;
                o_rd_en        = w_adv && (w_idx1 < r_cnt);
                o_rd_addr      = f_buf_addr(r_bank, w_idx1);
                n_state        = B_C1;
            end
            B_C1: begin
                n_out.char_out = f_enc6({r_prev[1:0], w_b1[7:4]});
                n_prev         = w_b1;
                o_rd_en        = w_adv && (w_idx2 < r_cnt);
                o_rd_addr      = f_buf_addr(r_bank, w_idx2);
                n_state        = B_C2;
            end
            B_C2: begin
                n_out.char_out = f_enc6({r_prev[3:0], w_b2[7:6]});
                n_prev         = w_b2;
                n_state        = B_C3;
            end
            B_C3: begin
                n_out.char_out = f_enc6(r_prev[5:0]);
                o_rd_en        = w_adv && (w_idx3 < r_cnt);
                o_rd_addr      = f_buf_addr(r_bank, w_idx3);
                n_idx          = w_idx3;
                n_state        = (w_idx3 < r_cnt) ? B_C0 : B_NL;
            end
            B_NL: begin
                n_out.char_out = CHAR_NL;
                n_out.run_last = !r_eos;
                n_state        = r_eos ? B_SP : B_IDLE;
            end
            B_SP: begin
                n_out.char_out = CHAR_BIAS;
                n_state        = B_END;
            end
            B_END: begin
                n_out.char_out = CHAR_NL;
                n_out.run_last = 1'b1;
                n_state        = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else if (r_state == B_IDLE) begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (o_q_pop) begin
                r_has_line <= i_q_cmd.has_line;
                r_bank     <= i_q_cmd.bank;
                r_cnt      <= i_q_cmd.count;
                r_eos      <= i_q_cmd.eos;
            end
            if (w_adv) begin
                r_out_valid <= 1'b0;
            end
        end else if (w_adv) begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_prev      <= n_prev;
            r_out_valid <= 1'b1;
            r_out       <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_group_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_C0) |-> (r_has_line && (r_idx < r_cnt)))
        else $error("group start lies outside the buffered line");
`endif

endmodule

>>> rtl/core/uuencode_line_encoder_core.sv
// The request that completes a line queues its command; the back end pops it, then registers
// the length character. Throughput: one character per cycle within a line while not stalled;
// data requests are taken one per cycle while a line bank is free and the queue has room.
// Reset (synchronous, active low) empties the queue, clears the fill count and sets the
// line length to 45; line buffer contents are not cleared and are never read before written.
`timescale 1ns / 1ps

module uuencode_line_encoder_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [uule_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  uule_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output uule_pkg::t_out_item   o_out_data
);
    import uule_pkg::*;

    logic              w_q_full;
    logic              w_q_empty;
    logic              w_q_push;
    logic              w_q_pop;
    t_line_cmd         w_push_cmd;
    t_line_cmd         w_head_cmd;
    logic              w_line_done;
    logic              w_wr_en;
    logic [RAM_AW-1:0] w_wr_addr;
    logic [7:0]        w_wr_data;
    logic              w_rd_en;
    logic [RAM_AW-1:0] w_rd_addr;
    logic [7:0]        w_rd_data;

    uule_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_cmd     (w_push_cmd),
        .i_line_done (w_line_done),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    uule_line_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    uule_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_q_empty)
    );

    uule_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_cmd     (w_head_cmd),
        .o_q_pop     (w_q_pop),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_line_done (w_line_done),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> dv/uuencode_line_encoder_core_tb.sv
// Self-checking testbench for the uuencode line encoder core with its own character predictor.
`timescale 1ns / 1ps

module uuencode_line_encoder_core_tb;
    import uule_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_GAP   = 8;
    localparam int unsigned PHASE_ITEMS = 21;

    // Predicts the character stream of each request and checks what the block emits.
    class uu_char_tracker;
        bit [CNT_W-1:0] line_len;
        bit [CNT_W-1:0] fill;
        bit [7:0]       line_buf [MAX_LINE_BYTES];
        t_out_item      want_chars [$];
        int unsigned    errors;
        int unsigned    n_requests;
        int unsigned    n_chars;
        int unsigned    n_lines;

        function new();
            line_len   = CNT_W'(MAX_LINE_BYTES);
            fill       = '0;
            errors     = 0;
            n_requests = 0;
            n_chars    = 0;
            n_lines    = 0;
        endfunction

        function void set_line_len(bit [CNT_W-1:0] v);
            line_len = v;
        endfunction

        function int unsigned pending();
            return want_chars.size();
        endfunction

        function void push_char(bit [6:0] c);
            t_out_item it;
            it.char_out = c;
            it.run_last = 1'b0;
            want_chars.push_back(it);
        endfunction

        function bit [6:0] six_to_char(bit [5:0] v);
            return {1'b0, v} + CHAR_BIAS;
        endfunction

        function void push_line();
            bit [7:0] b0;
            bit [7:0] b1;
            bit [7:0] b2;
            push_char(six_to_char(fill));
            for (int unsigned i = 0; i < fill; i += 3) begin
                b0 = line_buf[i];
                b1 = (i + 1 < fill) ? line_buf[i + 1] : 8'h00;
                b2 = (i + 2 < fill) ? line_buf[i + 2] : 8'h00;
                push_char(six_to_char(b0[7:2]));
                push_char(six_to_char({b0[1:0], b1[7:4]}));
                push_char(six_to_char({b1[3:0], b2[7:6]}));
                push_char(six_to_char(b2[5:0]));
            end
            push_char(CHAR_NL);
            fill = '0;
            n_lines++;
        endfunction

        function void predict_request(t_in_item req);
            int unsigned eff;
            int unsigned had;
            had = want_chars.size();
            // A length of zero behaves as one, anything past the buffer size as the maximum.
            eff = (line_len == 0) ? 1 : ((line_len > MAX_LINE_BYTES) ? MAX_LINE_BYTES : line_len);
            n_requests++;
            if (req.kind == KIND_DATA) begin
                if (fill < MAX_LINE_BYTES) begin
                    line_buf[fill] = req.data_byte;
                    fill++;
                end
                if (fill >= eff) push_line();
            end else begin
                if (fill != 0) push_line();
                push_char(CHAR_BIAS);
                push_char(CHAR_NL);
            end
            if (want_chars.size() > had) want_chars[want_chars.size() - 1].run_last = 1'b1;
        endfunction

        function void check_char(t_out_item got);
            t_out_item exp_c;
            n_chars++;
            if (want_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, got char %0d last %0b",
                         $time, got.char_out, got.run_last);
                errors++;
                return;
            end
            exp_c = want_chars.pop_front();
            if (got.char_out !== exp_c.char_out) begin
                $display("%0t: char_out mismatch: expected %0d, got %0d",
                         $time, exp_c.char_out, got.char_out);
                errors++;
            end
            if (got.run_last !== exp_c.run_last) begin
                $display("%0t: run_last mismatch: expected %0b, got %0b",
                         $time, exp_c.run_last, got.run_last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CNT_W-1:0]     i_cfg_data  = '0;
    logic                 o_cfg_ready;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;

    uu_char_tracker       sb = new();
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    int unsigned          hold_reqs     = 0;
    int unsigned          hold_seen     = 0;
    int unsigned          hold_left     = 0;
    int unsigned          cycle_cnt     = 0;

    uuencode_line_encoder_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver side: a requested hold-off wins over the random stalls.
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen   <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_char(o_out_data);
    end

    // Valid stays high from one request to the next unless a gap is chosen.
    task automatic send_req(logic kind, logic [7:0] data_byte);
        t_in_item req;
        req.kind      = kind;
        req.data_byte = data_byte;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.predict_request(req);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // A byte that finishes no line leaves nothing to wait for, so allow its pipeline to settle.
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_line_len(logic [CNT_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_line_len(v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_req();
        if ($urandom_range(15) == 0) send_req(KIND_EOS, 8'($urandom_range(255)));
        else send_req(KIND_DATA, 8'($urandom_range(255)));
    endtask

    initial begin
        logic [CNT_W-1:0] phase_len [9];
        phase_len = '{6'd45, 6'd3, 6'd63, 6'd1, 6'd0, 6'd17, 6'd46, 6'd2, 6'd30};
        phase_len[8] = CNT_W'($urandom_range(4, 44));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest lines, zero length, partial and empty flushes.
        write_line_len(6'd1);
        send_req(KIND_DATA, 8'h00);
        send_req(KIND_DATA, 8'hFF);
        write_line_len(6'd0);
        send_req(KIND_DATA, 8'h80);
        write_line_len(6'd2);
        send_req(KIND_DATA, 8'hAA);
        send_req(KIND_DATA, 8'h55);
        write_line_len(6'd3);
        send_req(KIND_DATA, 8'h0F);
        send_req(KIND_DATA, 8'hF0);
        send_req(KIND_DATA, 8'h3C);
        send_req(KIND_DATA, 8'h81);
        send_req(KIND_EOS, 8'h00);
        send_req(KIND_EOS, 8'hFF);
        // Shortening the line while five bytes are buffered sends all six at the next byte.
        write_line_len(6'd45);
        for (int i = 1; i <= 5; i++) send_req(KIND_DATA, 8'(i));
        write_line_len(6'd2);
        send_req(KIND_DATA, 8'h06);
        write_line_len(6'd63);
        send_req(KIND_DATA, 8'h7E);
        send_req(KIND_EOS, 8'h5A);

        for (int p = 0; p < 9; p++) begin
            write_line_len(phase_len[p]);
            case (p / 3)
                0: begin
                    send_idle_pct <= 18;
                    recv_idle_pct <= 48;
                end
                1: begin
                    send_idle_pct <= 48;
                    recv_idle_pct <= 18;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            // Short lines under a long receiver hold-off fill the block and back-pressure the input.
            if (p == 1 || p == 7) hold_reqs <= hold_reqs + 1;
            repeat (PHASE_ITEMS) send_random_req();
        end

        drain();
        $display("Covered %0d requests giving %0d lines and %0d characters,",
                 sb.n_requests, sb.n_lines, sb.n_chars);
        $display("over line lengths 0 to 63, three idle mixes and two receiver hold-offs.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
